@@ design/ovn_pkg.sv @@
// ============================================================================
// ovn_pkg
// Shared constants, types and register codes for the octave value noise core.
// ============================================================================
package ovn_pkg;

    localparam int SIDE        = 64;
    localparam int POS_W       = $clog2(SIDE);
    localparam int ADDR_W      = 2 * POS_W;
    localparam int MAX_OCT     = 7;
    localparam int OCT_W       = 3;
    localparam int SEED_W      = 16;
    localparam int BIAS_W      = 16;
    localparam int WEIGHT_W    = 32;
    localparam int NUM_W       = 51;   // 7 * 65535 * (2^32-1) fits
    localparam int DEN_W       = 35;
    localparam int PADDR_W     = 3;

    localparam logic [PADDR_W-1:0] REG_OCTAVE_COUNT = 3'd0;
    localparam logic [PADDR_W-1:0] REG_BIAS         = 3'd4;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Datapath commands issued by the controller.
    typedef struct packed {
        logic load;        // capture request, start octave 0
        logic seed_wr;     // write seed into grid
        logic rd_issue;    // present corner read address
        logic [1:0] corner;
        logic rd_capture;  // latch read data of previous corner
        logic blend_row;   // row blends
        logic blend_col;   // column blend
        logic acc;         // accumulate octave
        logic wdiv_start;  // start weight division
        logic wdiv_step;
        logic next_oct;
        logic ndiv_start;  // start final division
        logic ndiv_step;
        logic result_load;
    } ovn_cmd_t;

    typedef struct packed {
        logic is_query;
        logic last_oct;
        logic wdiv_done;
        logic ndiv_done;
    } ovn_status_t;

endpackage

@@ design/ovn_if.sv @@
// ============================================================================
// ovn_if
// Valid/ready channel interfaces for requests and results.
// ============================================================================
interface ovn_req_if;
    import ovn_pkg::*;
    logic              valid;
    logic              ready;
    logic              action;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [SEED_W-1:0] seed_value;
    modport source (output valid, action, pos_x, pos_y, seed_value, input ready);
    modport sink   (input valid, action, pos_x, pos_y, seed_value, output ready);
endinterface

interface ovn_res_if;
    import ovn_pkg::*;
    logic              valid;
    logic              ready;
    logic [SEED_W-1:0] noise;
    modport source (output valid, noise, input ready);
    modport sink   (input valid, noise, output ready);
endinterface

@@ design/ovn_ctrl.sv @@
// ============================================================================
// ovn_ctrl
// Sequencer: per octave four corner reads, two blend steps, accumulate and,
// all but last, bit-serial weight division; then bit-serial normalization.
// ============================================================================
module ovn_ctrl
    import ovn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    output logic        res_valid,
    input  logic        res_ready,
    input  ovn_status_t status,
    output ovn_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD0  = 4'd1;
    localparam logic [3:0] S_RD1  = 4'd2;
    localparam logic [3:0] S_RD2  = 4'd3;
    localparam logic [3:0] S_RD3  = 4'd4;
    localparam logic [3:0] S_CAP  = 4'd5;
    localparam logic [3:0] S_ROW  = 4'd6;
    localparam logic [3:0] S_COL  = 4'd7;
    localparam logic [3:0] S_ACC  = 4'd8;
    localparam logic [3:0] S_WDIV = 4'd9;
    localparam logic [3:0] S_NDIV = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;
    localparam logic [3:0] S_WRT  = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       res_valid_reg, res_valid_next;

    assign res_valid = res_valid_reg;
    // A new request may enter while the previous result waits, as long as
    // it cannot overwrite it before delivery.
    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_WRT;
                end
            end
            S_WRT:
            begin
                if (status.is_query)
                begin
                    cmd.rd_issue = 1'b1;
                    cmd.corner   = 2'd0;
                    state_next   = S_RD1;
                end
                else
                begin
                    cmd.seed_wr = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_RD0:
            begin
                cmd.rd_issue = 1'b1;
                cmd.corner   = 2'd0;
                state_next   = S_RD1;
            end
            S_RD1:
            begin
                cmd.rd_issue   = 1'b1;
                cmd.corner     = 2'd1;
                cmd.rd_capture = 1'b1;
                state_next     = S_RD2;
            end
            S_RD2:
            begin
                cmd.rd_issue   = 1'b1;
                cmd.corner     = 2'd2;
                cmd.rd_capture = 1'b1;
                state_next     = S_RD3;
            end
            S_RD3:
            begin
                cmd.rd_issue   = 1'b1;
                cmd.corner     = 2'd3;
                cmd.rd_capture = 1'b1;
                state_next     = S_CAP;
            end
            S_CAP:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = S_ROW;
            end
            S_ROW:
            begin
                cmd.blend_row  = 1'b1;
                state_next     = S_COL;
            end
            S_COL:
            begin
                cmd.blend_col = 1'b1;
                state_next    = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (status.last_oct)
                begin
                    cmd.ndiv_start = 1'b1;
                    state_next     = S_NDIV;
                end
                else
                begin
                    cmd.wdiv_start = 1'b1;
                    state_next     = S_WDIV;
                end
            end
            S_WDIV:
            begin
                cmd.wdiv_step = 1'b1;
                if (status.wdiv_done)
                begin
                    cmd.next_oct = 1'b1;
                    state_next   = S_RD0;
                end
            end
            S_NDIV:
            begin
                cmd.ndiv_step = 1'b1;
                if (status.ndiv_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    cmd.result_load = 1'b1;
                    res_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

@@ design/ovn_dpath.sv @@
// ============================================================================
// ovn_dpath
// Seed grid memory, bilinear blend, octave weighting and dividers.
// ============================================================================
module ovn_dpath
    import ovn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ovn_cmd_t          cmd,
    output ovn_status_t       status,
    input  logic              in_action,
    input  logic [POS_W-1:0]  in_x,
    input  logic [POS_W-1:0]  in_y,
    input  logic [SEED_W-1:0] in_seed,
    input  logic [OCT_W-1:0]  octave_count,
    input  logic [BIAS_W-1:0] bias,
    output logic [SEED_W-1:0] noise
);

    localparam int OIDX_W = $clog2(MAX_OCT);
    localparam int LOG_SIDE = POS_W;

    logic [SEED_W-1:0] grid_mem [SIDE*SIDE];
    logic [SEED_W-1:0] rd_data_reg;

    logic              act_reg;
    logic [POS_W-1:0]  x_reg, y_reg;
    logic [SEED_W-1:0] seed_reg;
    logic [OCT_W-1:0]  nocts_reg;
    logic [BIAS_W-1:0] bias_reg;
    logic [OIDX_W-1:0] oct_reg;
    logic [1:0]        cap_idx_reg;

    logic [SEED_W-1:0] s_reg [4];
    logic [32:0]       top_reg, bot_reg;
    logic [SEED_W-1:0] v16_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;

    // weight divider: (weight<<8)/bias, 40-bit dividend
    logic [39:0]       wq_reg;
    logic [BIAS_W:0]   wr_reg;
    logic [5:0]        wcnt_reg;
    // final divider
    logic [NUM_W:0]    nq_reg;
    logic [DEN_W:0]    nr_reg;
    logic [DEN_W-1:0]  nd_reg;
    logic [5:0]        ncnt_reg;
    logic [SEED_W-1:0] noise_reg;

    // pitch shift = LOG_SIDE - oct, floored at zero
    logic [OIDX_W:0]   sh;
    logic [POS_W:0]    pmask_ext;
    logic [POS_W-1:0]  pmask, x1, y1, x2, y2, ox, oy;
    logic [POS_W:0]    pitch;
    logic [16:0]       bx, by;
    logic [POS_W-1:0]  rx, ry;

    always_comb
    begin
        if (32'(oct_reg) >= LOG_SIDE)
            sh = '0;
        else
            sh = (OIDX_W+1)'(LOG_SIDE - 32'(oct_reg));
        pitch     = (POS_W+1)'(1) << sh;
        pmask_ext = pitch - (POS_W+1)'(1);
        pmask     = pmask_ext[POS_W-1:0];
        ox        = x_reg & pmask;
        oy        = y_reg & pmask;
        x1        = x_reg & ~pmask;
        y1        = y_reg & ~pmask;
        x2        = POS_W'(x1 + pitch[POS_W-1:0]);
        y2        = POS_W'(y1 + pitch[POS_W-1:0]);
        // offset * 65536 / pitch, pitch a power of two
        bx        = 17'({ox, 16'd0} >> sh);
        by        = 17'({oy, 16'd0} >> sh);
        rx        = (cmd.rd_issue && cmd.corner[0]) ? x2 : x1;
        ry        = (cmd.rd_issue && cmd.corner[1]) ? y2 : y1;
    end

    assign status.is_query  = act_reg;
    assign status.last_oct  = (32'(oct_reg) + 1 >= 32'(nocts_reg)) ||
                              (32'(oct_reg) + 1 >= MAX_OCT);
    assign status.wdiv_done = (wcnt_reg == 6'd0);
    assign status.ndiv_done = (ncnt_reg == 6'd0);
    assign noise = noise_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.seed_wr)
            grid_mem[{y_reg, x_reg}] <= seed_reg;
        rd_data_reg <= grid_mem[{ry, rx}];
    end

    logic [49:0] col_sum;
    logic [49:0] v_rnd;
    logic [16:0] bx_n, by_n;
    logic [BIAS_W:0] wr_sh, nd_sub_w;
    logic [DEN_W:0]  nr_sh;

    always_comb
    begin
        bx_n    = 17'h10000 - bx;
        by_n    = 17'h10000 - by;
        col_sum = 50'(by_n) * 50'(top_reg) + 50'(by) * 50'(bot_reg);
        v_rnd   = col_sum + 50'(33'h080000000);
        wr_sh   = {wr_reg[BIAS_W-1:0], wq_reg[39]};
        nd_sub_w = wr_sh - {1'b0, bias_reg};
        nr_sh   = {nr_reg[DEN_W-1:0], nq_reg[NUM_W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcnt_reg <= '0;
            ncnt_reg <= '0;
        end
        else
        begin
            if (cmd.wdiv_start)
                wcnt_reg <= 6'd40;
            else if (cmd.wdiv_step && wcnt_reg != 0)
                wcnt_reg <= wcnt_reg - 6'd1;
            if (cmd.ndiv_start)
                ncnt_reg <= 6'(NUM_W + 1);
            else if (cmd.ndiv_step && ncnt_reg != 0)
                ncnt_reg <= ncnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg    <= in_action;
            x_reg      <= in_x;
            y_reg      <= in_y;
            seed_reg   <= in_seed;
            nocts_reg  <= (octave_count == '0) ? OCT_W'(1) : octave_count;
            bias_reg   <= (bias == '0) ? BIAS_W'(1) : bias;
            oct_reg    <= '0;
            weight_reg <= WEIGHT_W'(65536);
            num_reg    <= '0;
            den_reg    <= '0;
            cap_idx_reg <= '0;
        end
        if (cmd.rd_capture)
        begin
            s_reg[cap_idx_reg] <= rd_data_reg;
            cap_idx_reg        <= cap_idx_reg + 2'd1;
        end
        if (cmd.blend_row)
        begin
            top_reg <= 33'(34'(bx_n) * 34'(s_reg[0])) + 33'(34'(bx) * 34'(s_reg[1]));
            bot_reg <= 33'(34'(bx_n) * 34'(s_reg[2])) + 33'(34'(bx) * 34'(s_reg[3]));
        end
        if (cmd.blend_col)
            v16_reg <= (v_rnd[49:32] > 18'd65535) ? 16'hFFFF : v_rnd[47:32];
        if (cmd.acc)
        begin
            num_reg <= num_reg + NUM_W'(48'(v16_reg) * 48'(weight_reg));
            den_reg <= den_reg + DEN_W'(weight_reg);
        end
        if (cmd.wdiv_start)
        begin
            wq_reg <= {weight_reg, 8'd0};
            wr_reg <= '0;
        end
        else if (cmd.wdiv_step && wcnt_reg != 0)
        begin
            if (!nd_sub_w[BIAS_W] || wr_reg[BIAS_W-1] || wr_sh >= {1'b0, bias_reg})
            begin
                wr_reg <= wr_sh - {1'b0, bias_reg};
                wq_reg <= {wq_reg[38:0], 1'b1};
            end
            else
            begin
                wr_reg <= wr_sh;
                wq_reg <= {wq_reg[38:0], 1'b0};
            end
        end
        if (cmd.next_oct)
        begin
            weight_reg <= (wq_reg[39:32] != 8'd0) ? '1 : wq_reg[31:0];
            oct_reg    <= oct_reg + OIDX_W'(1);
            cap_idx_reg <= '0;
        end
        if (cmd.ndiv_start)
        begin
            // dividend num + den/2, last octave's term folded in directly
            nq_reg <= (NUM_W+1)'(num_reg + NUM_W'(v16_reg) * NUM_W'(weight_reg))
                      + (NUM_W+1)'((den_reg + DEN_W'(weight_reg)) >> 1);
            nd_reg <= den_reg + DEN_W'(weight_reg);
            nr_reg <= '0;
        end
        else if (cmd.ndiv_step && ncnt_reg != 0)
        begin
            if (nr_sh >= {1'b0, nd_reg})
            begin
                nr_reg <= nr_sh - {1'b0, nd_reg};
                nq_reg <= {nq_reg[NUM_W-1:0], 1'b1};
            end
            else
            begin
                nr_reg <= nr_sh;
                nq_reg <= {nq_reg[NUM_W-1:0], 1'b0};
            end
        end
        if (cmd.result_load)
            noise_reg <= (nq_reg[NUM_W:16] != '0) ? 16'hFFFF : nq_reg[15:0];
    end

endmodule

@@ design/octave_value_noise_2d_core.sv @@
// ============================================================================
// octave_value_noise_2d_core
// Octave value noise over a 64x64 seed grid.
// ============================================================================
// Channels: req (action, pos_x, pos_y, seed_value) and res (noise), both
// valid/ready; a request is taken when valid and ready are high together.
// A write request (action 0) stores one seed and gives no result; the
// sequencer passes through its write state before it is ready again. A
// query (action 1) raises its result once every octave and the final
// division are done; the sequencer is idle again as the result is loaded,
// so the next request can be taken while it waits. The octave loop and
// the serial dividers, one quotient bit a cycle, set a query's latency.
// Only one request is in flight; ready is high while the sequencer idles.
// A finished result sits in an output register; if the receiver stalls,
// the next request may still be taken and is held before its own result
// until the earlier one is taken.
// Reset clears control and sets octave_count to 1, bias_q8_8 to 512. The
// seed grid is undefined until written.
// Registers (APB): 0x0 octave_count, 0x4 bias_q8_8.
// ============================================================================
module octave_value_noise_2d_core
    import ovn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    ovn_req_if.sink            req,
    ovn_res_if.source          res
);

    logic [OCT_W-1:0]  octave_count_reg;
    logic [BIAS_W-1:0] bias_reg;
    ovn_cmd_t          cmd;
    ovn_status_t       status;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg <= OCT_W'(1);
            bias_reg         <= BIAS_W'(512);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                REG_OCTAVE_COUNT: octave_count_reg <= pwdata[OCT_W-1:0];
                REG_BIAS:         bias_reg <= pwdata[BIAS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_OCTAVE_COUNT: prdata = 32'(octave_count_reg);
            REG_BIAS:         prdata = 32'(bias_reg);
            default:          prdata = '0;
        endcase
    end

    ovn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .status    (status),
        .cmd       (cmd)
    );

    ovn_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_action    (req.action),
        .in_x         (req.pos_x),
        .in_y         (req.pos_y),
        .in_seed      (req.seed_value),
        .octave_count (octave_count_reg),
        .bias         (bias_reg),
        .noise        (res.noise)
    );

endmodule

@@ design/ovn_checker.sv @@
// ============================================================================
// ovn_checker
// Port-level checks on the noise core.
// ============================================================================
module ovn_checker
    import ovn_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              res_valid,
    input logic              res_ready,
    input logic [SEED_W-1:0] noise,
    input logic              pready
);

    // a stalled result keeps its value
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(noise))
        else $error("result dropped or changed under stall");

    // the core never takes a request in back-to-back cycles
    a_req_gap: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    // a query needs many cycles before its result
    a_res_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(res_valid))
        else $error("result too early");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind octave_value_noise_2d_core ovn_checker u_ovn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .noise     (res.noise),
    .pready    (pready)
);

@@ bench/octave_value_noise_2d_core_test.sv @@
// ============================================================================
// octave_value_noise_2d_core_test
// Drives seed writes and noise queries through the request channel, predicts
// each query's noise in fixed point and checks results in order, over several
// octave_count and bias settings written over APB while the core is idle.
// ============================================================================
module octave_value_noise_2d_core_test;
    import ovn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              action;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [SEED_W-1:0] seed_value;
    } noise_req_t;

    localparam int LIMIT_CYCLES = 4000000;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    ovn_req_if req ();
    ovn_res_if res ();

    octave_value_noise_2d_core dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req(req.sink), .res(res.source)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // predictor state
    logic [SEED_W-1:0] grid_copy [SIDE*SIDE];
    bit                written [SIDE*SIDE];
    logic [2:0]        oct_reg;
    logic [15:0]       bias_reg;

    noise_req_t        pending_reqs[$];
    logic [SEED_W-1:0] expected_noise[$];
    int                mismatches;
    int                cycle_count;
    int                hold_off;
    bit                req_accepted;

    function automatic logic [63:0] octave_blend(int x, int y, int p);
        logic [63:0] bx, by, top, bot, v;
        int x1, y1, x2, y2;
        x1 = x & ~(p - 1) & (SIDE - 1);
        y1 = y & ~(p - 1) & (SIDE - 1);
        x2 = (x1 + p) & (SIDE - 1);
        y2 = (y1 + p) & (SIDE - 1);
        bx = (64'(x & (p - 1)) << 16) / p;
        by = (64'(y & (p - 1)) << 16) / p;
        top = (64'd65536 - bx) * grid_copy[y1*SIDE+x1] + bx * grid_copy[y1*SIDE+x2];
        bot = (64'd65536 - bx) * grid_copy[y2*SIDE+x1] + bx * grid_copy[y2*SIDE+x2];
        v = ((64'd65536 - by) * top + by * bot + (64'd1 << 31)) >> 32;
        if (v > 65535)
            v = 65535;
        return v;
    endfunction

    function automatic logic [SEED_W-1:0] noise_predict(int x, int y);
        logic [63:0] w, num, den, r, b;
        int n, p;
        n = (oct_reg == 0) ? 1 : oct_reg;
        b = (bias_reg == 0) ? 1 : bias_reg;
        w = 65536;
        num = 0;
        den = 0;
        for (int o = 0; o < n && o < MAX_OCT; o++)
        begin
            p = SIDE >> o;
            if (p == 0)
                p = 1;
            num += octave_blend(x, y, p) * w;
            den += w;
            w = (w << 8) / b;
            if (w > 64'hFFFF_FFFF)
                w = 64'hFFFF_FFFF;
        end
        r = (num + den / 2) / den;
        if (r > 65535)
            r = 65535;
        return r[15:0];
    endfunction

    // all corners that any octave of a query may read
    function automatic bit corners_written(int x, int y);
        int n, p, x1, y1, x2, y2;
        n = (oct_reg == 0) ? 1 : oct_reg;
        for (int o = 0; o < n; o++)
        begin
            p = SIDE >> o;
            if (p == 0)
                p = 1;
            x1 = x & ~(p - 1) & (SIDE - 1);
            y1 = y & ~(p - 1) & (SIDE - 1);
            x2 = (x1 + p) & (SIDE - 1);
            y2 = (y1 + p) & (SIDE - 1);
            if (!written[y1*SIDE+x1] || !written[y1*SIDE+x2] ||
                !written[y2*SIDE+x1] || !written[y2*SIDE+x2])
                return 0;
        end
        return 1;
    endfunction

    // coordinates touched by any octave of a query in [0,15] or at the far edge
    function automatic bit in_window(int v);
        return v <= 16 || v == 32 || v == 48 || v == 56 || v == 60 || v == 62 || v == 63;
    endfunction

    // driver
    int gap_left;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            gap_left = 0;
        end
        else if (req.valid && !req_accepted)
        begin
        end
        else if (gap_left > 0)
        begin
            req.valid <= 1'b0;
            gap_left--;
        end
        else if (pending_reqs.size() > 0)
        begin
            noise_req_t it;
            it = pending_reqs.pop_front();
            req.valid      <= 1'b1;
            req.action     <= it.action;
            req.pos_x      <= it.pos_x;
            req.pos_y      <= it.pos_y;
            req.seed_value <= it.seed_value;
            gap_left = $urandom_range(0, 8);
        end
        else
            req.valid <= 1'b0;
    end

    // predict at acceptance
    always @(posedge clk)
    begin
        req_accepted = rst_n && req.valid && req.ready;
        if (req_accepted)
        begin
            if (req.action == ACT_WRITE)
            begin
                grid_copy[req.pos_y*SIDE + req.pos_x] = req.seed_value;
                written[req.pos_y*SIDE + req.pos_x] = 1;
            end
            else
                expected_noise.push_back(noise_predict(req.pos_x, req.pos_y));
        end
    end

    // receiver stalls
    int stall_left;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            stall_left = 0;
        end
        else if (hold_off > 0)
        begin
            res.ready <= 1'b0;
            hold_off--;
        end
        else if (stall_left > 0)
        begin
            res.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            res.ready <= 1'b1;
            if (res.valid)
                stall_left = $urandom_range(0, 8);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_noise.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result noise=%h", res.noise);
            end
            else
            begin
                logic [SEED_W-1:0] e;
                e = expected_noise.pop_front();
                if (e !== res.noise)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("noise mismatch: expected %h actual %h", e, res.noise);
                end
            end
        end
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_OCTAVE_COUNT)
            oct_reg = data[2:0];
        else
            bias_reg = data[15:0];
    endtask

    task automatic drain_idle();
        wait (pending_reqs.size() == 0);
        @(negedge clk);
        while (req.valid || expected_noise.size() != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    function automatic noise_req_t make_req(logic a, int x, int y, int s);
        noise_req_t r;
        r.action = a;
        r.pos_x = POS_W'(x);
        r.pos_y = POS_W'(y);
        r.seed_value = SEED_W'(s);
        return r;
    endfunction

    // queue a query only where every corner it reads has a seed
    task automatic push_query(int x, int y);
        if (corners_written(x, y))
            pending_reqs.push_back(make_req(ACT_QUERY, x, y, $urandom));
    endtask

    // mirror grid writes at push time to know coverage
    task automatic push_write(int x, int y, int s);
        pending_reqs.push_back(make_req(ACT_WRITE, x, y, s));
        written[y*SIDE+x] = 1;
    endtask

    int settings_oct[6] = '{1, 7, 3, 0, 5, 2};
    int settings_bias[6] = '{512, 1, 65535, 0, 256, 300};

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req.valid = 1'b0;
        req.action = ACT_WRITE;
        req.pos_x = '0;
        req.pos_y = '0;
        req.seed_value = '0;
        res.ready = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        hold_off = 0;
        req_accepted = 1'b0;
        oct_reg = 1;
        bias_reg = 512;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill the window that the queries read; grid_copy follows acceptance
        for (int yy = 0; yy < SIDE; yy++)
            for (int xx = 0; xx < SIDE; xx++)
                if (in_window(xx) && in_window(yy))
                    push_write(xx, yy, (xx == 0 && yy == 0) ? 0 :
                               (xx == 1 && yy == 0) ? 65535 : $urandom);
        drain_idle();

        for (int s = 0; s < 6; s++)
        begin
            apb_write(REG_OCTAVE_COUNT, settings_oct[s]);
            apb_write(REG_BIAS, settings_bias[s]);
            if (s == 0)
            begin
                // directed corners and extremes
                push_query(0, 0);
                push_query(63, 63);
                push_query(63, 0);
                push_query(0, 63);
                push_query(15, 8);
                push_write(5, 5, 65535);
                push_write(6, 5, 65535);
                push_query(5, 5);
                push_write(0, 0, 0);
                push_query(1, 1);
            end
            if (s == 1)
            begin
                // long receiver hold-off so the core stalls its input
                hold_off = 2000;
                for (int k = 0; k < 6; k++)
                    push_query($urandom_range(0, 15), $urandom_range(0, 15));
            end
            for (int k = 0; k < 170; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                    push_write($urandom_range(0, 16), $urandom_range(0, 16), $urandom);
                else
                    push_query($urandom_range(0, 15), $urandom_range(0, 15));
            end
            drain_idle();
        end

        if (mismatches == 0 && expected_noise.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
